// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define SCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define SCSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// scsa_pkg
// Types, constants and helper functions of the size class space allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  // Geometry
  localparam int SEG_BITS           = 16;
  localparam int ZONE_BITS          = 31;
  localparam int ZONE_RESERVED_SEGS = 4;
  localparam int MAX_RADIX          = 16;
  localparam int RADIX_FIELD_BITS   = 6;

  localparam int RADIX_COUNT = MAX_RADIX + 1;
  localparam int SLOT_DEPTH  = 2 * RADIX_COUNT;
  localparam int IDX_W       = $clog2(SLOT_DEPTH);

  // Field widths
  localparam int REQ_W   = 31;
  localparam int REF_W   = 64;
  localparam int TYPE_W  = 2;
  localparam int RADIX_W = 5;   // allocate radix is 0..31

  localparam logic [REF_W-1:0] SEG_SIZE   = REF_W'(64'd1) << SEG_BITS;
  localparam logic [REF_W-1:0] SEG_MASK   = SEG_SIZE - REF_W'(64'd1);
  localparam logic [REF_W-1:0] ZONE_MASK  = (REF_W'(64'd1) << ZONE_BITS) - REF_W'(64'd1);
  localparam logic [REF_W-1:0] ZONE_HEAD  = REF_W'(ZONE_RESERVED_SEGS) << SEG_BITS;
  localparam logic [REF_W-1:0] RADIX_MASK =
    (REF_W'(64'd1) << RADIX_FIELD_BITS) - REF_W'(64'd1);

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch item, read slot entries
    logic commit;    // write back slots, iterator, result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;   // item in flight is a free
    logic out_ready; // result register can take a new item
  } dp_status_t;

  // Smallest r with 2^r >= req; 0 and 1 give 0
  function automatic logic [RADIX_W-1:0] size_to_radix(input logic [REQ_W-1:0] req);
    logic [REQ_W-1:0]   m;
    logic [RADIX_W-1:0] r;
    m = req - REQ_W'(1);
    r = '0;
    if (req > REQ_W'(1)) begin
      for (int i = 0; i < REQ_W; i++) begin
        if (m[i]) r = RADIX_W'(i + 1);
      end
    end
    return r;
  endfunction

  // Entry index: class * RADIX_COUNT + radix
  function automatic logic [IDX_W-1:0] slot_index(input logic cls,
                                                  input logic [RADIX_W-1:0] radix);
    return cls ? IDX_W'(RADIX_COUNT) + IDX_W'(radix) : IDX_W'(radix);
  endfunction

endpackage

// ===== hw/rtl/scsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsa_ctrl
// Request sequencer: accept and lookup, then write-back and result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scsa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  scsa_pkg::dp_status_t  status_i,
  output scsa_pkg::dp_cmd_t     cmd_o
);

  scsa_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    s_ready_o     = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      scsa_pkg::ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
        if (s_valid_i) state_d = scsa_pkg::ST_UPDATE;
      end
      scsa_pkg::ST_UPDATE: begin
        // a free has no result; an allocate waits for the result register
        if (status_i.is_free || status_i.out_ready) begin
          cmd_o.commit = 1'b1;
          state_d      = scsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scsa_pkg::ST_IDLE;
      end
    endcase
  end

  `SCSA_ASSERT(a_capture_to_update, cmd_o.capture |=> state_q == scsa_pkg::ST_UPDATE, "capture did not move to update")
  `SCSA_ASSERT(a_stall_holds, (state_q == scsa_pkg::ST_UPDATE && !status_i.is_free && !status_i.out_ready) |=> state_q == scsa_pkg::ST_UPDATE, "left update while result blocked")

endmodule

// ===== hw/rtl/scsa_dp.sv =====
// ----------------------------------------------------------------------------
// scsa_dp
// Slot memories, iterator, item registers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scsa_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  scsa_pkg::dp_cmd_t                  cmd_i,
  output scsa_pkg::dp_status_t               status_o,
  input  logic                               s_func_i,
  input  logic [scsa_pkg::TYPE_W-1:0]        s_type_i,
  input  logic [scsa_pkg::REQ_W-1:0]         s_req_i,
  input  logic [scsa_pkg::REF_W-1:0]         s_fref_i,
  input  logic                               cfg_we_i,
  input  logic [scsa_pkg::REF_W-1:0]         cfg_wdata_i,
  input  logic                               m_ready_i,
  output logic                               m_valid_o,
  output logic [scsa_pkg::REF_W-1:0]         m_alloc_ref_o,
  output logic                               m_dirty_o
);

  localparam int IW = scsa_pkg::IDX_W;
  localparam int RW = scsa_pkg::REF_W;
  localparam int AW = scsa_pkg::RADIX_W;

  // Slot memories with per-entry valid bits (invalid reads as empty)
  logic [RW-1:0]                   single_mem [scsa_pkg::SLOT_DEPTH];
  logic [RW-1:0]                   pack_mem   [scsa_pkg::SLOT_DEPTH];
  logic [scsa_pkg::SLOT_DEPTH-1:0] single_vld_q, pack_vld_q;

  // Item registers
  logic            func_q;
  logic [AW-1:0]   radix_q;
  logic            use_slot_q;
  logic [IW-1:0]   idx_q;
  logic [RW-1:0]   fref_off_q;
  logic [RW-1:0]   iter_off_q;
  logic [RW-1:0]   single_rd_q, pack_rd_q;
  logic            single_vld_rd_q, pack_vld_rd_q;

  logic [RW-1:0]   iterator_q;
  logic            dirty_q;
  logic            out_valid_q;
  logic [RW-1:0]   out_ref_q;
  logic            out_dirty_q;

  // Lookup side
  logic            in_free, cls_in, fr_hit, al_cached, rd_use;
  logic [AW-1:0]   al_radix;
  logic [IW-1:0]   rd_idx;
  logic [RW-1:0]   iter_rnd, iter_off;

  always_comb begin
    in_free   = (s_func_i == scsa_pkg::FUNC_FREE);
    cls_in    = s_type_i[1];
    al_radix  = scsa_pkg::size_to_radix(s_req_i);
    fr_hit    = (s_fref_i[scsa_pkg::RADIX_FIELD_BITS-1:0] <
                 scsa_pkg::RADIX_FIELD_BITS'(scsa_pkg::MAX_RADIX));
    al_cached = (al_radix <= AW'(scsa_pkg::MAX_RADIX));
    rd_use    = in_free ? fr_hit : al_cached;
    rd_idx    = '0;
    if (rd_use) begin
      rd_idx = in_free ? scsa_pkg::slot_index(cls_in, s_fref_i[AW-1:0])
                       : scsa_pkg::slot_index(cls_in, al_radix);
    end
    // iterator rounded to a segment, skipping a zone's reserved head
    iter_rnd = (iterator_q + scsa_pkg::SEG_MASK) & ~scsa_pkg::SEG_MASK;
    iter_off = iter_rnd;
    if ((iter_rnd & scsa_pkg::ZONE_MASK) < scsa_pkg::ZONE_HEAD) begin
      iter_off = (iter_rnd & ~scsa_pkg::ZONE_MASK) | scsa_pkg::ZONE_HEAD;
    end
  end

  // Capture item and read both slot entries
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      radix_q         <= al_radix;
      use_slot_q      <= rd_use;
      idx_q           <= rd_idx;
      fref_off_q      <= s_fref_i & ~scsa_pkg::RADIX_MASK;
      iter_off_q      <= iter_off;
      single_rd_q     <= single_mem[rd_idx];
      pack_rd_q       <= pack_mem[rd_idx];
      single_vld_rd_q <= single_vld_q[rd_idx];
      pack_vld_rd_q   <= pack_vld_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= scsa_pkg::FUNC_ALLOC;
    end else if (cmd_i.capture) begin
      func_q <= s_func_i;
    end
  end

  // Write-back decision
  logic          single_full, pack_full, take_iter;
  logic          single_we, pack_we;
  logic [RW-1:0] single_wd, pack_wd;
  logic [RW-1:0] bytes, pack_adv, iter_next, alloc_off;

  always_comb begin
    single_full = single_vld_rd_q && (single_rd_q != '0);
    pack_full   = pack_vld_rd_q && (pack_rd_q != '0);
    bytes       = RW'(64'd1) << radix_q;
    pack_adv    = pack_rd_q + bytes;
    // iterator offset is segment aligned: small blocks leave a remainder
    iter_next   = iter_off_q +
                  ((radix_q >= AW'(scsa_pkg::SEG_BITS)) ? bytes : scsa_pkg::SEG_SIZE);
    take_iter   = 1'b0;
    single_we   = 1'b0;
    pack_we     = 1'b0;
    single_wd   = '0;
    pack_wd     = '0;
    alloc_off   = iter_off_q;
    if (func_q == scsa_pkg::FUNC_FREE) begin
      single_we = use_slot_q && !single_full;
      single_wd = fref_off_q;
    end else if (use_slot_q && single_full) begin
      alloc_off = single_rd_q;
      single_we = 1'b1;
    end else if (use_slot_q && pack_full) begin
      alloc_off = pack_rd_q;
      pack_we   = 1'b1;
      pack_wd   = ((pack_adv & scsa_pkg::SEG_MASK) == '0) ? '0 : pack_adv;
    end else begin
      take_iter = 1'b1;
      pack_we   = use_slot_q && (radix_q < AW'(scsa_pkg::SEG_BITS));
      pack_wd   = iter_off_q | bytes;
    end
  end

  // Slot memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && single_we) single_mem[idx_q] <= single_wd;
    if (cmd_i.commit && pack_we)   pack_mem[idx_q]   <= pack_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_vld_q <= '0;
      pack_vld_q   <= '0;
    end else if (cmd_i.commit) begin
      if (single_we) single_vld_q[idx_q] <= 1'b1;
      if (pack_we)   pack_vld_q[idx_q]   <= 1'b1;
    end
  end

  // Iterator and dirty flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iterator_q <= '0;
      dirty_q    <= 1'b0;
    end else if (cmd_i.commit && take_iter) begin
      iterator_q <= iter_next;
      dirty_q    <= 1'b1;
    end else if (cfg_we_i) begin
      iterator_q <= cfg_wdata_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && func_q == scsa_pkg::FUNC_ALLOC) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && func_q == scsa_pkg::FUNC_ALLOC) begin
      out_ref_q   <= alloc_off | RW'(radix_q);
      out_dirty_q <= dirty_q | take_iter;
    end
  end

  assign status_o.is_free   = (func_q == scsa_pkg::FUNC_FREE);
  assign status_o.out_ready = !out_valid_q || m_ready_i;
  assign m_valid_o          = out_valid_q;
  assign m_alloc_ref_o      = out_ref_q;
  assign m_dirty_o          = out_dirty_q;

  `SCSA_ASSERT(a_alloc_gives_result, (cmd_i.commit && func_q == scsa_pkg::FUNC_ALLOC) |=> out_valid_q, "allocate commit without result")
  `SCSA_ASSERT(a_iter_aligned, (cmd_i.commit && take_iter) |=> (iterator_q[scsa_pkg::SEG_BITS-1:0] == '0), "iterator left unaligned")

endmodule

// ===== hw/rtl/size_class_space_allocator_core.sv =====
// An accepted item is held in the item registers, then its result is written to
// the output register at write-back. A new item is accepted only after the last
// one has read the slot memory at accept and finished its write-back of the slot entry and iterator.
// A free gives no result; an allocate waits only while the output register is full.
// Reset (async, active low) empties all slots, clears the dirty flag and loads
// the iterator with zero; a configuration write loads the iterator unless an iterator write-back wins.
// ----------------------------------------------------------------------------
// size_class_space_allocator_core
// Media space allocator with per-class single and packing slots.
// ----------------------------------------------------------------------------
module size_class_space_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [30:0] request_bytes, [94:31] freed_ref, [95] zero
  input  logic [2:0]  s_axis_tuser,   // [0] func, [2:1] block_type
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] alloc_ref, [64] header_dirty, [71:65] zero
  // configuration
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i
);

  scsa_pkg::dp_cmd_t    cmd;
  scsa_pkg::dp_status_t status;
  logic [63:0]          alloc_ref;
  logic                 header_dirty;

  scsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  scsa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_func_i      (s_axis_tuser[0]),
    .s_type_i      (s_axis_tuser[2:1]),
    .s_req_i       (s_axis_tdata[30:0]),
    .s_fref_i      (s_axis_tdata[94:31]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .m_ready_i     (m_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .m_alloc_ref_o (alloc_ref),
    .m_dirty_o     (header_dirty)
  );

  assign m_axis_tdata = {7'd0, header_dirty, alloc_ref};

endmodule
